@@ hw/rtl/frsr_pkg.sv @@
// Shared types and constants for the four-motor speed ramp.
// No dependencies; every other RTL file of the block imports this package.
package frsr_pkg;

  localparam int MOTOR_COUNT = 4;

  localparam int GOAL_W  = 16;
  localparam int SPEED_W = 9;
  localparam int STEP_W  = 8;
  localparam int DUTY_W  = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = 8'd40;
  localparam int SPEED_LIMIT = 255;

  // Request type codes.
  localparam logic [1:0] REQ_GOALS   = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    DIR_FWD     = 2'd0,
    DIR_BRAKE   = 2'd1,
    DIR_BACK    = 2'd2,
    DIR_RELEASE = 2'd3
  } dir_t;

  typedef struct packed {
    dir_t              dir;
    logic [DUTY_W-1:0] duty;
  } drive_t;

  // Per-lane command decoded once from an accepted request.
  typedef struct packed {
    logic load;
    logic tick;
    logic rel_all;
  } lane_cmd_t;

endpackage

@@ hw/rtl/frsr_ifs.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on frsr_pkg for field widths.
interface frsr_req_if;
  import frsr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [GOAL_W-1:0] goal_m0;
  logic signed [GOAL_W-1:0] goal_m1;
  logic signed [GOAL_W-1:0] goal_m2;
  logic signed [GOAL_W-1:0] goal_m3;
  modport source(output valid, req_type, goal_m0, goal_m1, goal_m2, goal_m3, input ready);
  modport sink(input valid, req_type, goal_m0, goal_m1, goal_m2, goal_m3, output ready);
endinterface

interface frsr_rsp_if;
  import frsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        dir_m0;
  logic [1:0]        dir_m1;
  logic [1:0]        dir_m2;
  logic [1:0]        dir_m3;
  logic [DUTY_W-1:0] duty_m0;
  logic [DUTY_W-1:0] duty_m1;
  logic [DUTY_W-1:0] duty_m2;
  logic [DUTY_W-1:0] duty_m3;
  modport source(output valid, dir_m0, dir_m1, dir_m2, dir_m3,
                 duty_m0, duty_m1, duty_m2, duty_m3, input ready);
  modport sink(input valid, dir_m0, dir_m1, dir_m2, dir_m3,
               duty_m0, duty_m1, duty_m2, duty_m3, output ready);
endinterface

@@ hw/rtl/frsr_lane.sv @@
// One motor lane: goal, speed and latched drive registers plus the ramp step.
// Depends on frsr_pkg.
module frsr_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  frsr_pkg::lane_cmd_t               cmd,
  input  logic signed [frsr_pkg::GOAL_W-1:0] goal_in,
  input  logic [frsr_pkg::STEP_W-1:0]       ramp_step,
  output frsr_pkg::drive_t                  drive_nxt
);
  import frsr_pkg::*;

  logic signed [SPEED_W-1:0] speed;
  logic signed [SPEED_W-1:0] goal;
  drive_t                    drive;

  logic signed [SPEED_W-1:0] goal_sat;
  logic signed [SPEED_W-1:0] speed_abs;
  drive_t                    drive_lat;
  logic signed [10:0]        speed_wide;
  logic signed [10:0]        goal_wide;
  logic signed [10:0]        step_wide;
  logic signed [10:0]        stepped;
  logic signed [10:0]        diff;
  logic [9:0]                diff_mag;
  logic [8:0]                snap_lim;
  logic signed [SPEED_W-1:0] speed_next;

  always_comb begin
    if (goal_in > 16'sd255) begin
      goal_sat = 9'sd255;
    end else if (goal_in < -16'sd255) begin
      goal_sat = -9'sd255;
    end else begin
      goal_sat = goal_in[SPEED_W-1:0];
    end

    // Drive is latched from the speed before it moves.
    speed_abs = speed[SPEED_W-1] ? -speed : speed;
    drive_lat.duty = speed_abs[DUTY_W-1:0];
    if (speed > 9'sd0) begin
      drive_lat.dir = DIR_FWD;
    end else if (speed == 9'sd0) begin
      drive_lat.dir = DIR_BRAKE;
    end else begin
      drive_lat.dir = DIR_BACK;
    end

    speed_wide = {{2{speed[SPEED_W-1]}}, speed};
    goal_wide  = {{2{goal[SPEED_W-1]}}, goal};
    step_wide  = $signed({3'b000, ramp_step});
    stepped    = (speed < goal) ? speed_wide + step_wide : speed_wide - step_wide;
    diff       = stepped - goal_wide;
    diff_mag   = diff[10] ? 10'(-diff) : diff[9:0];
    snap_lim   = {ramp_step, 1'b0};
    // Without a snap the speed always stays inside the goal range.
    speed_next = (diff_mag < {1'b0, snap_lim}) ? goal : stepped[SPEED_W-1:0];

    if (cmd.rel_all) begin
      drive_nxt.dir  = DIR_RELEASE;
      drive_nxt.duty = '0;
    end else if (cmd.tick) begin
      drive_nxt = drive_lat;
    end else begin
      drive_nxt = drive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed      <= '0;
      goal       <= '0;
      drive.dir  <= DIR_RELEASE;
      drive.duty <= '0;
    end else if (cmd.rel_all) begin
      speed      <= '0;
      goal       <= '0;
      drive.dir  <= DIR_RELEASE;
      drive.duty <= '0;
    end else if (cmd.tick) begin
      speed <= speed_next;
      drive <= drive_lat;
    end else if (cmd.load) begin
      goal <= goal_sat;
    end
  end

endmodule

@@ hw/rtl/frsr_merge.sv @@
// Output stage: gathers the four lane drives into one registered response.
// Depends on frsr_pkg and frsr_rsp_if.
module frsr_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  frsr_pkg::drive_t drive_nxt [frsr_pkg::MOTOR_COUNT],
  output logic             can_load,
  frsr_rsp_if.source       rsp
);
  import frsr_pkg::*;

  logic   valid;
  drive_t held [MOTOR_COUNT];

  assign can_load = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= drive_nxt;
    end
  end

  assign rsp.valid   = valid;
  assign rsp.dir_m0  = held[0].dir;
  assign rsp.dir_m1  = held[1].dir;
  assign rsp.dir_m2  = held[2].dir;
  assign rsp.dir_m3  = held[3].dir;
  assign rsp.duty_m0 = held[0].duty;
  assign rsp.duty_m1 = held[1].duty;
  assign rsp.duty_m2 = held[2].duty;
  assign rsp.duty_m3 = held[3].duty;

endmodule

@@ hw/rtl/four_motor_speed_ramp_core.sv @@
// Four-motor speed ramp, top level. A response appears in the cycle after its
// request is accepted. One request per cycle is taken while the response is not
// stalled, as the response register drains while the next request is taken.
// Reset (rst, synchronous) zeroes speeds, goals and duties, puts every drive in
// release, loads ramp_step with 40, empties output.
module four_motor_speed_ramp_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [frsr_pkg::STEP_W-1:0] cfg_wdata,
  frsr_req_if.sink                    req,
  frsr_rsp_if.source                  rsp
);
  import frsr_pkg::*;

  // The ramp step is the one configuration register; it is shared by all lanes.
  logic [STEP_W-1:0] ramp_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step <= STEP_RESET;
    end else if (cfg_we) begin
      ramp_step <= cfg_wdata;
    end
  end

  // A request is taken whenever the response register is empty or being
  // drained this cycle, so requests stream back to back.
  logic      accept;
  logic      can_load;
  lane_cmd_t cmd;

  assign req.ready = can_load;
  assign accept    = req.valid && req.ready;

  // Decode once; an unused request type leaves all lanes untouched but still
  // produces a response with the current drives.
  always_comb begin
    cmd.load    = accept && (req.req_type == REQ_GOALS);
    cmd.tick    = accept && (req.req_type == REQ_TICK);
    cmd.rel_all = accept && (req.req_type == REQ_RELEASE);
  end

  logic signed [GOAL_W-1:0] goal [MOTOR_COUNT];
  drive_t                   drive_nxt [MOTOR_COUNT];

  assign goal[0] = req.goal_m0;
  assign goal[1] = req.goal_m1;
  assign goal[2] = req.goal_m2;
  assign goal[3] = req.goal_m3;

  // One lane per motor. Each lane holds its own speed, goal and latched drive,
  // and presents the drive as it will be after the current request.
  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
    frsr_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .goal_in   (goal[m]),
      .ramp_step (ramp_step),
      .drive_nxt (drive_nxt[m])
    );
  end

  // The merge stage captures the four lane drives as one response.
  frsr_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .drive_nxt (drive_nxt),
    .can_load  (can_load),
    .rsp       (rsp)
  );

  // Every accepted request leaves a response waiting in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("response missing after accepted request");

  // A release request reports every motor released; zero duty is checked on motors 0 and 3.
  a_release_rsp: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_RELEASE) |=>
      (rsp.dir_m0 == DIR_RELEASE && rsp.dir_m1 == DIR_RELEASE &&
       rsp.dir_m2 == DIR_RELEASE && rsp.dir_m3 == DIR_RELEASE &&
       rsp.duty_m0 == '0 && rsp.duty_m3 == '0))
    else $error("release response does not show released drives");

  // A stalled response must block new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while response is stalled");

endmodule

@@ test/frsr_drive_check.sv @@
// Watches the request, response and configuration ports of the four-motor speed ramp,
// predicts the four latched drives after each request and compares the responses.
// Depends on frsr_pkg and the channel interfaces in frsr_ifs.sv.
module frsr_drive_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [frsr_pkg::STEP_W-1:0] cfg_wdata,
  frsr_req_if                         req,
  frsr_rsp_if                         rsp,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import frsr_pkg::*;

  typedef drive_t [MOTOR_COUNT-1:0] drive_set_t;

  logic [STEP_W-1:0] ramp_step;
  int                speed_now  [MOTOR_COUNT];
  int                speed_goal [MOTOR_COUNT];
  drive_set_t        drives;
  drive_set_t        drive_queue [$];

  function automatic int saturate_goal(logic signed [GOAL_W-1:0] g);
    int v;
    v = int'(g);
    if (v > SPEED_LIMIT) return SPEED_LIMIT;
    if (v < -SPEED_LIMIT) return -SPEED_LIMIT;
    return v;
  endfunction

  // Latch the drive from the present speed, then slew toward the goal.
  function automatic void tick_motor(int m);
    int s;
    int g;
    int st;
    int span;
    s = speed_now[m];
    g = speed_goal[m];
    st = int'(ramp_step);
    if (s > 0) drives[m].dir = DIR_FWD;
    else if (s == 0) drives[m].dir = DIR_BRAKE;
    else drives[m].dir = DIR_BACK;
    drives[m].duty = DUTY_W'(s < 0 ? -s : s);
    s = (s < g) ? s + st : s - st;
    span = (s > g) ? s - g : g - s;
    if (span < 2 * st) s = g;
    speed_now[m] = s;
  endfunction

  function automatic void apply_request(logic [1:0] kind, logic signed [GOAL_W-1:0] g0,
                                        logic signed [GOAL_W-1:0] g1,
                                        logic signed [GOAL_W-1:0] g2,
                                        logic signed [GOAL_W-1:0] g3);
    case (kind)
      REQ_GOALS: begin
        speed_goal[0] = saturate_goal(g0);
        speed_goal[1] = saturate_goal(g1);
        speed_goal[2] = saturate_goal(g2);
        speed_goal[3] = saturate_goal(g3);
      end
      REQ_TICK: begin
        for (int m = 0; m < MOTOR_COUNT; m++) tick_motor(m);
      end
      REQ_RELEASE: begin
        for (int m = 0; m < MOTOR_COUNT; m++) begin
          speed_now[m] = 0;
          speed_goal[m] = 0;
          drives[m] = '{dir: DIR_RELEASE, duty: '0};
        end
      end
      default: ;
    endcase
    drive_queue.push_back(drives);
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    drive_set_t want;
    drive_set_t seen;
    if (rst) begin
      errors = 0;
      ramp_step = STEP_RESET;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        speed_now[m] = 0;
        speed_goal[m] = 0;
        drives[m] = '{dir: DIR_RELEASE, duty: '0};
      end
      drive_queue.delete();
    end else begin
      // A response belongs to an earlier request, so it is checked before
      // a request accepted at the same edge is predicted.
      if (rsp.valid && rsp.ready) begin
        if (drive_queue.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          want = drive_queue.pop_front();
          seen[0] = '{dir: dir_t'(rsp.dir_m0), duty: rsp.duty_m0};
          seen[1] = '{dir: dir_t'(rsp.dir_m1), duty: rsp.duty_m1};
          seen[2] = '{dir: dir_t'(rsp.dir_m2), duty: rsp.duty_m2};
          seen[3] = '{dir: dir_t'(rsp.dir_m3), duty: rsp.duty_m3};
          for (int m = 0; m < MOTOR_COUNT; m++) begin
            if (seen[m].dir !== want[m].dir)
              report_mismatch($sformatf("motor %0d dir %0d, expected %0d",
                                        m, seen[m].dir, want[m].dir));
            if (seen[m].duty !== want[m].duty)
              report_mismatch($sformatf("motor %0d duty %0d, expected %0d",
                                        m, seen[m].duty, want[m].duty));
          end
        end
      end
      if (cfg_we) ramp_step = cfg_wdata;
      if (req.valid && req.ready)
        apply_request(req.req_type, req.goal_m0, req.goal_m1, req.goal_m2, req.goal_m3);
    end
    pending = drive_queue.size();
  end

endmodule

@@ test/tb_four_motor_speed_ramp_core.sv @@
// Top of the testbench for four_motor_speed_ramp_core: clock, reset, request
// stimulus, response flow control and the verdict. Needs frsr_pkg, frsr_ifs.sv,
// the RTL of the block and frsr_drive_check.sv.
module tb_four_motor_speed_ramp_core;
  timeunit 1ns;
  timeprecision 1ps;
  import frsr_pkg::*;

  // The request type that the block does not decode; it must leave all state alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Cycles of the long response stall used to back the block up.
  localparam int HOLD_CYCLES = 64;
  // Random requests per configuration phase; eight phases give about 900 in all.
  localparam int PHASE_ITEMS = 110;
  localparam int PHASES = 8;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;
  int                errors;
  int                pending;

  // steady turns off idling on both sides; long_hold stalls the response side.
  bit   steady;
  bit   long_hold;
  event hold_start;

  frsr_req_if req ();
  frsr_rsp_if rsp ();

  four_motor_speed_ramp_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp)
  );

  frsr_drive_check u_drive_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Response side. Ready changes only at the falling edge. It drops with a chance
  // of about 31 percent, always in a long hold, and else never while steady is set.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = !long_hold && (steady || $urandom_range(99) >= 31);
    end
  end

  // The long hold counts its own cycles, so the sender keeps offering requests
  // the whole time and the block has to fill up and push back on its input.
  initial begin
    long_hold = 1'b0;
    forever begin
      @(hold_start);
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      long_hold = 1'b0;
    end
  end

  // Offers one request and returns at the falling edge after it was taken.
  // Valid is left high, so back-to-back requests keep it high without a glitch.
  // During a gap the payload carries junk that the block must ignore.
  task automatic send_request(input logic [1:0] kind,
                              input logic signed [GOAL_W-1:0] g0,
                              input logic signed [GOAL_W-1:0] g1,
                              input logic signed [GOAL_W-1:0] g2,
                              input logic signed [GOAL_W-1:0] g3);
    if (!steady) begin
      while ($urandom_range(99) < 31) begin
        req.valid = 1'b0;
        req.req_type = 2'($urandom);
        req.goal_m0 = GOAL_W'($urandom);
        req.goal_m1 = GOAL_W'($urandom);
        req.goal_m2 = GOAL_W'($urandom);
        req.goal_m3 = GOAL_W'($urandom);
        @(negedge clk);
      end
    end
    req.valid = 1'b1;
    req.req_type = kind;
    req.goal_m0 = g0;
    req.goal_m1 = g1;
    req.goal_m2 = g2;
    req.goal_m3 = g3;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Goals mostly fall inside the speed range, where the ramp does its real
  // work; some sit on the range ends or just past them, and the rest use the
  // full 16 bits so that saturation and every goal bit get exercised.
  function automatic logic signed [GOAL_W-1:0] pick_goal();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return GOAL_W'(int'($urandom_range(510)) - SPEED_LIMIT);
    if (roll < 70) begin
      case ($urandom_range(4))
        0: return GOAL_W'(SPEED_LIMIT);
        1: return GOAL_W'(-SPEED_LIMIT);
        2: return GOAL_W'(SPEED_LIMIT + 1);
        3: return GOAL_W'(-SPEED_LIMIT - 1);
        default: return '0;
      endcase
    end
    return GOAL_W'($urandom);
  endfunction

  // Mostly ticks, so speeds get time to ramp between goal changes. Goal
  // updates, the odd stop, release and an unused type make up the rest.
  task automatic random_request();
    int roll;
    roll = $urandom_range(99);
    if (roll < 18)
      send_request(REQ_GOALS, pick_goal(), pick_goal(), pick_goal(), pick_goal());
    else if (roll < 21)
      send_request(REQ_GOALS, '0, '0, '0, '0);
    else if (roll < 92)
      send_request(REQ_TICK, pick_goal(), pick_goal(), pick_goal(), pick_goal());
    else if (roll < 96)
      send_request(REQ_RELEASE, pick_goal(), pick_goal(), pick_goal(), pick_goal());
    else
      send_request(REQ_UNUSED, pick_goal(), pick_goal(), pick_goal(), pick_goal());
  endtask

  // The step register is only written with the block idle: the sender stops
  // and waits until every response is back, then writes for one cycle.
  task automatic set_ramp_step(input logic [STEP_W-1:0] value);
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [STEP_W-1:0] phase_step;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    steady = 1'b0;
    req.valid = 1'b0;
    req.req_type = REQ_GOALS;
    req.goal_m0 = '0;
    req.goal_m1 = '0;
    req.goal_m2 = '0;
    req.goal_m3 = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with the step at its reset value of 40.
    // A tick straight after reset latches brake with zero duty everywhere.
    send_request(REQ_TICK, '0, '0, '0, '0);
    // Goals beyond the speed range saturate to the range ends.
    send_request(REQ_GOALS, 16'sh7FFF, -16'sh8000, 16'sd256, -16'sd256);
    repeat (4) send_request(REQ_TICK, '0, '0, '0, '0);
    // The unused type must report the latched drives and change nothing.
    send_request(REQ_UNUSED, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_request(REQ_TICK, '0, '0, '0, '0);
    // Goals exactly on the range ends, at zero and one off zero.
    send_request(REQ_GOALS, 16'sd255, -16'sd255, 16'sd0, 16'sd1);
    repeat (3) send_request(REQ_TICK, '0, '0, '0, '0);
    // Stop the motors: zero goals, then ticks that ramp down and snap.
    send_request(REQ_GOALS, '0, '0, '0, '0);
    repeat (3) send_request(REQ_TICK, '0, '0, '0, '0);
    // Release from motion puts every drive in release with zero duty.
    send_request(REQ_RELEASE, 16'sh5555, -16'sh5556, 16'sh00FF, -16'sh0100);
    send_request(REQ_TICK, '0, '0, '0, '0);
    // Near-extreme goals, then a speed resting on its goal is stepped down and snapped back.
    send_request(REQ_GOALS, -16'sd1, 16'sd1, -16'sh7FFF, 16'sh7FFE);
    repeat (4) send_request(REQ_TICK, '0, '0, '0, '0);

    // Random phases, each with its own ramp step. Steps of 1 and 255 come first,
    // then 40, a zero step where speeds never move, a tiny step and random ones.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_step = 8'd1;
        1: phase_step = 8'd255;
        2: phase_step = 8'd40;
        3: phase_step = 8'd0;
        4: phase_step = 8'd2;
        default: phase_step = STEP_W'($urandom_range(1, 255));
      endcase
      set_ramp_step(phase_step);
      // Phase 2 runs without idling on either side and opens with a long
      // response stall, so requests pile up against a full block. Phase 5
      // repeats the stall with random idling.
      steady = (p == 2);
      if (p == 2 || p == 5) -> hold_start;
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
    end
    steady = 1'b0;

    // Drain: every response back, then a wait for anything stray.
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every gap and stall at its worst.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
